FILE: src/gwce_pkg.sv
package gwce_pkg;

  // default sizes
  localparam int unsigned VERTICES_DEF    = 32;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  // port widths of the word fields
  localparam int unsigned VTX_W = 5;
  localparam int unsigned WGT_W = 16;

  // input word kinds
  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR2,
    ST_START,
    ST_ISTART,
    ST_RD,
    ST_CHK,
    ST_SCORE,
    ST_CMP,
    ST_FIN,
    ST_SUBA,
    ST_SUBRD,
    ST_SUBWR,
    ST_OUT
  } state_e;

  // lowest set bit of a mask, zero when empty
  function automatic logic [5:0] first_set(input logic [63:0] m);
    logic [5:0] r;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      if (m[k]) r = 6'(k);
    end
    return r;
  endfunction

endpackage

FILE: src/greedy_weighted_clique_extract.sv
// Greedy weighted clique extractor. A write word (kind 0) stores a weight on both halves of a
// symmetric VERTICES x VERTICES matrix held in one single-port-write, registered-read memory; a
// valid edge takes one write per half, an invalid one is dropped. An extract word (kind 1)
// runs one greedy round and answers with one word per clique member (start vertex first, then
// ascending), or one word with found low. Every weight look-up is a memory read plus a check,
// and each candidate reads its weights to the members until a zero turns up. When a clique is
// found, the minimum is subtracted from every pair inside it before the result words go out.
// The memory is addressed by the two vertex numbers side by side, so it holds
// 2^(2*clog2(VERTICES)) entries. After reset a clearing pass zeroes every entry of the matrix;
// no word is taken during it.
module greedy_weighted_clique_extract #(
  parameter int unsigned VERTICES    = gwce_pkg::VERTICES_DEF,
  parameter int unsigned WEIGHT_BITS = gwce_pkg::WEIGHT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [gwce_pkg::VTX_W-1:0] vertex_a_i,
  input  logic [gwce_pkg::VTX_W-1:0] vertex_b_i,
  input  logic [gwce_pkg::WGT_W-1:0] weight_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [gwce_pkg::VTX_W-1:0] vertex_o,
  output logic [gwce_pkg::WGT_W-1:0] clique_min_o,
  output logic                       found_o,
  output logic                       last_o
);
  import gwce_pkg::*;

  localparam int unsigned VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int unsigned AW = 2 * VW;
  localparam int unsigned NN = 1 << AW;
  localparam int unsigned SW = $clog2(VERTICES + 1);
  localparam int unsigned PW = SW + WEIGHT_BITS;

  typedef logic [VERTICES-1:0]    mask_t;
  typedef logic [WEIGHT_BITS-1:0] wgt_t;

  state_e state_q, state_d;

  // weight store
  wgt_t            mem [NN];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  wgt_t            mem_wdata, rd_q;

  logic [AW-1:0]   clr_q;
  logic [VW-1:0]   wa_q, wb_q;
  wgt_t            ww_q;
  logic [VW-1:0]   s_q, i_q, a_q, b_q;
  mask_t           trial_q, rem_q, best_q, arem_q, brem_q, orem_q;
  logic [SW-1:0]   size_q;
  wgt_t            mn_q, cand_q, best_min_q;
  logic            have_q, candv_q;
  logic [PW-1:0]   prod_q, best_score_q;
  logic [VW-1:0]   best_start_q;
  logic [VTX_W-1:0] vert_q;
  logic            found_q, last_q;

  logic            in_acc, wr_ok;
  logic [VW-1:0]   in_a, in_b, rem_first, brem_first, arem_first, orem_first;
  logic            last_i, last_s;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_a   = VW'(vertex_a_i);
  assign in_b   = VW'(vertex_b_i);
  assign wr_ok  = (vertex_a_i != vertex_b_i) && (32'(vertex_a_i) < VERTICES)
                  && (32'(vertex_b_i) < VERTICES);
  assign rem_first  = VW'(first_set(64'(rem_q)));
  assign brem_first = VW'(first_set(64'(brem_q)));
  assign arem_first = VW'(first_set(64'(arem_q)));
  assign orem_first = VW'(first_set(64'(orem_q)));
  assign last_i = (i_q == VW'(VERTICES - 1));
  assign last_s = (s_q == VW'(VERTICES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == AW'(NN - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_EXTRACT) state_d = ST_START;
          else if (wr_ok) state_d = ST_WR2;
        end
      end
      ST_WR2:    state_d = ST_IDLE;
      ST_START:  state_d = ST_ISTART;
      ST_ISTART: state_d = ST_RD;
      ST_RD:     state_d = ST_CHK;
      ST_CHK: begin
        if (rd_q == '0 || rem_q == '0) state_d = last_i ? ST_SCORE : ST_ISTART;
        else state_d = ST_RD;
      end
      ST_SCORE: state_d = ST_CMP;
      ST_CMP:   state_d = last_s ? ST_FIN : ST_START;
      ST_FIN:   state_d = (best_score_q == '0) ? ST_OUT : ST_SUBA;
      ST_SUBA:  state_d = (arem_q == '0) ? ST_OUT : ST_SUBRD;
      ST_SUBRD: state_d = (brem_q == '0) ? ST_SUBA : ST_SUBWR;
      ST_SUBWR: state_d = ST_SUBRD;
      ST_OUT:   if (!out_stall_i && orem_q == '0) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // memory port control and handshake outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      ST_IDLE: begin
        mem_we    = in_acc && (kind_i == KIND_WRITE) && wr_ok;
        mem_waddr = {in_a, in_b};
        mem_wdata = WEIGHT_BITS'(weight_i);
      end
      ST_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = {wb_q, wa_q};
        mem_wdata = ww_q;
      end
      ST_RD:    mem_raddr = {rem_first, i_q};
      ST_SUBRD: mem_raddr = {a_q, brem_first};
      ST_SUBWR: begin
        mem_we    = 1'b1;
        mem_waddr = {a_q, b_q};
        mem_wdata = rd_q - best_min_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = (state_q == ST_OUT);
  assign vertex_o     = vert_q;
  assign clique_min_o = WGT_W'(found_q ? best_min_q : '0);
  assign found_o      = found_q;
  assign last_o       = last_q;

  // weight memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        wa_q <= in_a;
        wb_q <= in_b;
        ww_q <= WEIGHT_BITS'(weight_i);
        s_q  <= '0;
        best_q       <= '0;
        best_min_q   <= '0;
        best_score_q <= '0;
        best_start_q <= '0;
      end
      ST_START: begin
        trial_q <= mask_t'(1) << s_q;
        size_q  <= SW'(1);
        mn_q    <= '0;
        have_q  <= 1'b0;
        i_q     <= '0;
      end
      ST_ISTART: begin
        rem_q   <= trial_q;
        cand_q  <= mn_q;
        candv_q <= have_q;
      end
      ST_RD: rem_q <= rem_q & ~(mask_t'(1) << rem_first);
      ST_CHK: begin
        if (rd_q == '0) begin
          i_q <= i_q + VW'(1);
        end else if (rem_q == '0) begin
          trial_q <= trial_q | (mask_t'(1) << i_q);
          size_q  <= size_q + SW'(1);
          mn_q    <= (!candv_q || rd_q < cand_q) ? rd_q : cand_q;
          have_q  <= 1'b1;
          i_q     <= i_q + VW'(1);
        end else if (!candv_q || rd_q < cand_q) begin
          cand_q  <= rd_q;
          candv_q <= 1'b1;
        end
      end
      ST_SCORE: prod_q <= PW'(size_q) * PW'(mn_q);
      ST_CMP: begin
        if (prod_q > best_score_q) begin
          best_score_q <= prod_q;
          best_q       <= trial_q;
          best_min_q   <= mn_q;
          best_start_q <= s_q;
        end
        s_q <= s_q + VW'(1);
      end
      ST_FIN: begin
        arem_q  <= best_q;
        vert_q  <= '0;
        found_q <= 1'b0;
        last_q  <= 1'b1;
        orem_q  <= '0;
      end
      ST_SUBA: begin
        if (arem_q == '0) begin
          vert_q  <= VTX_W'(best_start_q);
          found_q <= 1'b1;
          orem_q  <= best_q & ~(mask_t'(1) << best_start_q);
          last_q  <= ((best_q & ~(mask_t'(1) << best_start_q)) == '0);
        end else begin
          a_q    <= arem_first;
          arem_q <= arem_q & ~(mask_t'(1) << arem_first);
          brem_q <= best_q & ~(mask_t'(1) << arem_first);
        end
      end
      ST_SUBRD: begin
        b_q    <= brem_first;
        brem_q <= brem_q & ~(mask_t'(1) << brem_first);
      end
      ST_OUT: begin
        if (!out_stall_i && orem_q != '0) begin
          vert_q <= VTX_W'(orem_first);
          orem_q <= orem_q & ~(mask_t'(1) << orem_first);
          last_q <= ((orem_q & ~(mask_t'(1) << orem_first)) == '0);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: src/gwce_checker.sv
module gwce_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [gwce_pkg::WGT_W-1:0] clique_min_o,
  input logic                       found_o,
  input logic                       last_o
);

  // a stalled word stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // no new word is taken while results are shown
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken during result delivery");

  // an empty round answers with one closing word
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> last_o && clique_min_o == '0)
    else $error("empty round word malformed");

  // a found clique always has a positive minimum
  a_found_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> clique_min_o != '0)
    else $error("found clique with zero minimum");

endmodule

bind greedy_weighted_clique_extract gwce_checker u_gwce_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .clique_min_o (clique_min_o),
  .found_o      (found_o),
  .last_o       (last_o)
);

FILE: verif/tb_greedy_weighted_clique_extract.sv
`timescale 1ns / 100ps

module tb_greedy_weighted_clique_extract;
  import gwce_pkg::*;

  localparam int unsigned NV        = 32;
  localparam int unsigned IDLE_MAX  = 400000;
  localparam int unsigned N_RANDOM  = 90;
  localparam int unsigned HOLD_LEN  = 20000;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [WGT_W-1:0] clique_min;
    logic             found;
    logic             last;
  } member_word_t;

  // clique predictor and store of awaited member words
  class clique_board;
    logic [WGT_W-1:0] weights [NV][NV];
    member_word_t     awaited [$];
    int unsigned      errors;

    function new();
      foreach (weights[i, j]) weights[i][j] = '0;
      errors = 0;
    endfunction

    // note an accepted input word and predict its member words
    function void note_word(logic kind, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
                            logic [WGT_W-1:0] w);
      logic [NV-1:0]   trial, best;
      int unsigned     size, mn, cand, best_min, best_start, wv;
      bit              have, cand_ok, ok;
      longint unsigned score, best_score;
      member_word_t    mw;
      if (kind == KIND_WRITE) begin
        if (a != b) begin
          weights[a][b] = w;
          weights[b][a] = w;
        end
        return;
      end
      best = '0;
      best_min = 0;
      best_score = 0;
      best_start = 0;
      for (int s = 0; s < NV; s++) begin
        size = 1;
        mn = 0;
        have = 0;
        trial = '0;
        trial[s] = 1'b1;
        for (int i = 0; i < NV; i++) begin
          ok = 1;
          cand = have ? mn : 0;
          cand_ok = have;
          for (int v = 0; v < NV && ok; v++) begin
            if (trial[v]) begin
              wv = weights[v][i];
              if (wv == 0) ok = 0;
              else if (!cand_ok || wv < cand) begin
                cand = wv;
                cand_ok = 1;
              end
            end
          end
          if (ok) begin
            trial[i] = 1'b1;
            size++;
            mn = cand;
            have = 1;
          end
        end
        score = longint'(size) * longint'(mn);
        if (score > best_score) begin
          best_score = score;
          best = trial;
          best_min = mn;
          best_start = s;
        end
      end
      if (best_score == 0) begin
        mw = '{vertex: '0, clique_min: '0, found: 1'b0, last: 1'b1};
        awaited = {awaited, mw};
        return;
      end
      // take the minimum off every pair inside the winner
      for (int x = 0; x < NV; x++)
        for (int y = 0; y < NV; y++)
          if (x != y && best[x] && best[y]) weights[x][y] -= WGT_W'(best_min);
      mw = '{vertex: VTX_W'(best_start), clique_min: WGT_W'(best_min), found: 1'b1,
             last: 1'b0};
      awaited = {awaited, mw};
      for (int v = 0; v < NV; v++) begin
        if (v != best_start && best[v]) begin
          mw.vertex = VTX_W'(v);
          awaited = {awaited, mw};
        end
      end
      awaited[$].last = 1'b1;
    endfunction

    // compare one accepted member word with the oldest prediction
    function void check_word(member_word_t got);
      member_word_t exp;
      if (awaited.size() == 0) begin
        $error("unexpected member word vertex=%0d", got.vertex);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.vertex !== exp.vertex) begin
        $error("vertex: expected %0d got %0d", exp.vertex, got.vertex);
        errors++;
      end
      if (got.clique_min !== exp.clique_min) begin
        $error("clique_min: expected %0d got %0d", exp.clique_min, got.clique_min);
        errors++;
      end
      if (got.found !== exp.found) begin
        $error("found: expected %0d got %0d", exp.found, got.found);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d got %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             kind_i;
  logic [VTX_W-1:0] vertex_a_i;
  logic [VTX_W-1:0] vertex_b_i;
  logic [WGT_W-1:0] weight_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [VTX_W-1:0] vertex_o;
  logic [WGT_W-1:0] clique_min_o;
  logic             found_o;
  logic             last_o;

  clique_board board;
  int unsigned words_sent;
  bit          held_off;
  bit          drained_once;

  greedy_weighted_clique_extract dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .vertex_a_i, .vertex_b_i,
    .weight_i, .out_valid_o, .out_stall_i, .vertex_o, .clique_min_o, .found_o, .last_o
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // random gap length, mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // offer one word and wait for it to be taken, starting at a falling edge
  task automatic send_word(logic k, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
                           logic [WGT_W-1:0] w);
    in_valid_i <= 1'b1;
    kind_i     <= k;
    vertex_a_i <= a;
    vertex_b_i <= b;
    weight_i   <= w;
    do @(posedge clk_i); while (in_stall_o);
    board.note_word(k, a, b, w);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int unsigned n);
    if (n == 0) return;
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic put_edge(int unsigned a, int unsigned b, int unsigned w, bit gaps);
    send_word(KIND_WRITE, VTX_W'(a), VTX_W'(b), WGT_W'(w));
    if (gaps) idle_gap(gap_len());
  endtask

  task automatic run_round(bit gaps);
    send_word(KIND_EXTRACT, VTX_W'($urandom), VTX_W'($urandom), WGT_W'($urandom));
    if (gaps) idle_gap(gap_len());
  endtask

  // well-formed sequence: plant a clique with random weights, then extract
  task automatic plant_clique();
    int unsigned members [$];
    int unsigned k, v, wmax;
    k = $urandom_range(2, 5);
    wmax = ($urandom_range(0, 3) == 0) ? 16'hffff : 40;
    while (members.size() < k) begin
      v = $urandom_range(0, NV - 1);
      if (!(v inside {members})) members = {members, v};
    end
    foreach (members[i])
      for (int j = i + 1; j < k; j++)
        put_edge(members[i], members[j], $urandom_range(1, wmax), 1);
    repeat ($urandom_range(1, 2)) run_round(1);
  endtask

  // stimulus
  initial begin
    board        = new();
    words_sent   = 0;
    drained_once = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_WRITE;
    vertex_a_i  = '0;
    vertex_b_i  = '0;
    weight_i    = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty matrix, extremes, diagonal, zero weight, ties
    run_round(0);
    put_edge(0, 31, 16'hffff, 0);
    put_edge(7, 7, 16'h1234, 0);
    put_edge(3, 4, 0, 0);
    run_round(0);
    run_round(0);
    put_edge(1, 2, 5, 0);
    put_edge(2, 3, 7, 0);
    put_edge(1, 3, 9, 0);
    put_edge(10, 11, 15, 0);
    run_round(0);
    run_round(0);
    put_edge(20, 21, 4, 0);
    put_edge(22, 23, 4, 0);
    run_round(0);
    put_edge(31, 30, 1, 0);
    put_edge(31, 0, 16'h8000, 0);
    put_edge(30, 0, 16'h7fff, 0);
    run_round(0);
    run_round(1);

    // random part: mostly planted cliques, some noise writes
    while (words_sent < 20 + N_RANDOM) begin
      if ($urandom_range(0, 3) != 0) plant_clique();
      else repeat ($urandom_range(1, 4))
        put_edge($urandom_range(0, NV - 1), $urandom_range(0, NV - 1),
                 ($urandom_range(0, 3) == 0) ? 0 : $urandom, 1);
      // pause once until everything awaited has come
      if (!drained_once && words_sent >= 80) begin
        drained_once = 1;
        in_valid_i <= 1'b0;
        while (board.awaited.size() != 0) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.awaited.size() == 0)
      $display("PASS greedy_weighted_clique_extract");
    else
      $display("FAIL greedy_weighted_clique_extract");
    $finish;
  end

  // receiver stall, with one long hold-off while words keep coming
  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    held_off    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && words_sent >= 40) begin
        held_off = 1;
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk_i);
      end
      n = gap_len();
      if (n == 0) out_stall_i <= 1'b0;
      else begin
        out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_word('{vertex: vertex_o, clique_min: clique_min_o, found: found_o,
                         last: last_o});
  end

  // watchdog on cycles with no word moving
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
      if (idle >= IDLE_MAX) begin
        $display("FAIL greedy_weighted_clique_extract");
        $finish;
      end
    end
  end

endmodule
